// File: hw/rtl/first_fit_unit_allocator_macros.svh
// Assertion helpers shared by the allocator RTL.
// Both expect clk and rst_n in scope.
`ifndef FIRST_FIT_UNIT_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_UNIT_ALLOCATOR_MACROS_SVH

// Same-cycle implication
`define FFUA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ffua assertion failed");

// Next-cycle implication
`define FFUA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ffua assertion failed");

`endif

// File: hw/rtl/ffua_pkg.sv
`timescale 1ns / 1ps
package ffua_pkg;

  localparam int SIZE_W    = 11;
  localparam int VALUE_W   = 11;
  localparam int TAG_IN_W  = 10;
  localparam int TAG_MAX_W = 16;
  localparam int MEMSZ_W   = 11;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic STATUS_DONE  = 1'b0;
  localparam logic STATUS_NOFIT = 1'b1;

  localparam logic REG_MEM_SIZE = 1'b0;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_NOFIT = 2'd2
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [SIZE_W-1:0]   size;
    logic [TAG_IN_W-1:0] tag;
  } item_t;

  typedef struct packed {
    logic full;
    logic clearing;
  } front_ctl_t;

endpackage

// File: hw/rtl/ffua_if.sv
`timescale 1ns / 1ps
interface ffua_req_if;
  import ffua_pkg::*;
  logic                valid;
  logic                ready;
  logic                kind;
  logic [SIZE_W-1:0]   alloc_size;
  logic [TAG_IN_W-1:0] owner_tag;
  modport source (output valid, kind, alloc_size, owner_tag, input ready);
  modport sink (input valid, kind, alloc_size, owner_tag, output ready);
endinterface

interface ffua_rsp_if;
  import ffua_pkg::*;
  logic               valid;
  logic               ready;
  logic               status;
  logic [VALUE_W-1:0] value;
  modport source (output valid, status, value, input ready);
  modport sink (input valid, status, value, output ready);
endinterface

// File: hw/rtl/ffua_fifo.sv
`timescale 1ns / 1ps
`include "first_fit_unit_allocator_macros.svh"
module ffua_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ffua_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            pop_valid,
  output ffua_pkg::item_t pop_item
);
  import ffua_pkg::*;

  item_t             q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QDEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_item  = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_item;
    end
  end

  `FFUA_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= QCNT_W'(QDEPTH))
  `FFUA_ASSERT_IMPL(a_no_overflow, push, !full)
  `FFUA_ASSERT_IMPL(a_no_underflow, pop, cnt_r != '0)
  `FFUA_ASSERT_NEXT(a_first_push, push && !pop && cnt_r == '0, cnt_r == QCNT_W'(1))

endmodule

// File: hw/rtl/ffua_front.sv
`timescale 1ns / 1ps
module ffua_front #(
  parameter int MEM_UNITS = 1024
) (
  ffua_req_if.sink                      in_req,
  input  logic [$clog2(MEM_UNITS+1)-1:0] limit,
  input  ffua_pkg::front_ctl_t          ctl,
  output logic                          push,
  output ffua_pkg::item_t               push_item
);
  import ffua_pkg::*;

  logic nofit;

  // zero or longer than the active unit range can never fit
  assign nofit = (in_req.alloc_size == '0) || (32'(in_req.alloc_size) > 32'(limit));

  assign in_req.ready = !ctl.clearing && !ctl.full;
  assign push         = in_req.valid && in_req.ready;

  always_comb begin
    push_item.size = in_req.alloc_size;
    push_item.tag  = in_req.owner_tag;
    if (in_req.kind == KIND_FREE) begin
      push_item.op = OP_FREE;
    end else if (nofit) begin
      push_item.op = OP_NOFIT;
    end else begin
      push_item.op = OP_ALLOC;
    end
  end

endmodule

// File: hw/rtl/ffua_engine.sv
`timescale 1ns / 1ps
`include "first_fit_unit_allocator_macros.svh"
module ffua_engine #(
  parameter int MEM_UNITS = 1024,
  parameter int TAG_BITS  = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [$clog2(MEM_UNITS+1)-1:0] limit,
  input  logic                          q_valid,
  input  ffua_pkg::item_t               q_item,
  output logic                          q_pop,
  output logic                          clearing,
  ffua_rsp_if.source                    out_rsp
);
  import ffua_pkg::*;

  localparam int AW = $clog2(MEM_UNITS);
  localparam int CW = $clog2(MEM_UNITS + 1);
  localparam int WW = TAG_BITS + 1;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_ASCAN = 6'b000100,
    S_MARK  = 6'b001000,
    S_FSCAN = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t              st_r, st_nxt;
  logic [CW-1:0]       rd_idx_r, rd_idx_nxt;
  logic                pend_r, pend_nxt;
  logic [AW-1:0]       pidx_r, pidx_nxt;
  logic [AW-1:0]       widx_r, widx_nxt;
  logic [AW-1:0]       start_r, start_nxt;
  logic [SIZE_W-1:0]   run_r, run_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [SIZE_W-1:0]   left_r, left_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  logic [VALUE_W-1:0]  cnt_r, cnt_nxt;
  logic                res_status_r, res_status_nxt;
  logic [VALUE_W-1:0]  res_value_r, res_value_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]  out_value_r, out_value_nxt;

  logic [WW-1:0]        mem [MEM_UNITS];
  logic [WW-1:0]        rdata_r;
  logic                 re, we;
  logic [AW-1:0]        raddr, waddr;
  logic [WW-1:0]        wdata;
  logic                 rd_taken;
  logic [TAG_BITS-1:0]  rd_owner;
  logic [TAG_MAX_W-1:0] tag_ext;
  logic [SIZE_W-1:0]    run_inc;

  assign rd_taken = rdata_r[WW-1];
  assign rd_owner = rdata_r[TAG_BITS-1:0];
  assign tag_ext  = TAG_MAX_W'(q_item.tag);
  assign run_inc  = run_r + SIZE_W'(1);
  assign clearing = (st_r == S_CLEAR);

  assign out_rsp.valid  = out_valid_r;
  assign out_rsp.status = out_status_r;
  assign out_rsp.value  = out_value_r;

  always_comb begin
    st_nxt         = st_r;
    rd_idx_nxt     = rd_idx_r;
    pend_nxt       = pend_r;
    pidx_nxt       = pidx_r;
    widx_nxt       = widx_r;
    start_nxt      = start_r;
    run_nxt        = run_r;
    size_nxt       = size_r;
    left_nxt       = left_r;
    tag_nxt        = tag_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    re             = 1'b0;
    raddr          = rd_idx_r[AW-1:0];
    we             = 1'b0;
    waddr          = pidx_r;
    wdata          = '0;
    q_pop          = 1'b0;

    case (st_r)
      S_CLEAR: begin
        we         = 1'b1;
        waddr      = rd_idx_r[AW-1:0];
        rd_idx_nxt = rd_idx_r + CW'(1);
        if (rd_idx_r == CW'(MEM_UNITS - 1)) begin
          rd_idx_nxt = '0;
          st_nxt     = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          tag_nxt    = tag_ext[TAG_BITS-1:0];
          size_nxt   = q_item.size;
          rd_idx_nxt = '0;
          pend_nxt   = 1'b0;
          run_nxt    = '0;
          cnt_nxt    = '0;
          case (q_item.op)
            OP_ALLOC: st_nxt = S_ASCAN;
            OP_FREE:  st_nxt = S_FSCAN;
            default: begin
              res_status_nxt = STATUS_NOFIT;
              res_value_nxt  = '0;
              st_nxt         = S_RESP;
            end
          endcase
        end
      end
      S_ASCAN: begin
        if (rd_idx_r < limit) begin
          re         = 1'b1;
          rd_idx_nxt = rd_idx_r + CW'(1);
          pend_nxt   = 1'b1;
          pidx_nxt   = rd_idx_r[AW-1:0];
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (rd_taken) begin
            run_nxt = '0;
          end else begin
            if (run_r == '0) begin
              start_nxt = pidx_r;
            end
            run_nxt = run_inc;
            if (run_inc == size_r) begin
              widx_nxt = (run_r == '0) ? pidx_r : start_r;
              left_nxt = size_r;
              pend_nxt = 1'b0;
              st_nxt   = S_MARK;
            end
          end
        end else if (rd_idx_r >= limit) begin
          res_status_nxt = STATUS_NOFIT;
          res_value_nxt  = '0;
          st_nxt         = S_RESP;
        end
      end
      S_MARK: begin
        we       = 1'b1;
        waddr    = widx_r;
        wdata    = {1'b1, tag_r};
        widx_nxt = widx_r + AW'(1);
        left_nxt = left_r - SIZE_W'(1);
        if (left_r == SIZE_W'(1)) begin
          res_status_nxt = STATUS_DONE;
          res_value_nxt  = VALUE_W'(start_r);
          st_nxt         = S_RESP;
        end
      end
      S_FSCAN: begin
        if (rd_idx_r < CW'(MEM_UNITS)) begin
          re         = 1'b1;
          rd_idx_nxt = rd_idx_r + CW'(1);
          pend_nxt   = 1'b1;
          pidx_nxt   = rd_idx_r[AW-1:0];
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r && rd_taken && (rd_owner == tag_r)) begin
          we      = 1'b1;
          waddr   = pidx_r;
          wdata   = '0;
          cnt_nxt = cnt_r + VALUE_W'(1);
        end
        if (!pend_r && (rd_idx_r == CW'(MEM_UNITS))) begin
          res_status_nxt = STATUS_DONE;
          res_value_nxt  = cnt_r;
          st_nxt         = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          st_nxt         = S_IDLE;
        end
      end
      default: begin
        st_nxt     = S_CLEAR;
        rd_idx_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      rd_idx_r    <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      rd_idx_r    <= rd_idx_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r       <= pidx_nxt;
    widx_r       <= widx_nxt;
    start_r      <= start_nxt;
    run_r        <= run_nxt;
    size_r       <= size_nxt;
    left_r       <= left_nxt;
    tag_r        <= tag_nxt;
    cnt_r        <= cnt_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  `FFUA_ASSERT_IMPL(a_pop_idle, q_pop, st_r == S_IDLE)
  `FFUA_ASSERT_IMPL(a_run_below, st_r == S_ASCAN, run_r < size_r)
  `FFUA_ASSERT_IMPL(a_mark_left, st_r == S_MARK, left_r != '0)
  `FFUA_ASSERT_IMPL(a_load_resp, $rose(out_valid_r), $past(st_r == S_RESP))

endmodule

// File: hw/rtl/first_fit_unit_allocator.sv
// A free scans the whole unit store and clears the owner's units; an allocate scans up to
// the active range for the first fit and marks it, or answers no-fit if none is found;
// a zero or oversized allocate is answered no-fit without a scan.
// One request is in the engine at a time; the next starts in the cycle after the result
// is loaded; a result held by out_rsp.ready stalls the engine, the queue holds two more.
// After rst_n the unit store is swept clear with in_req.ready low.
// mem_size resets to MEM_UNITS.
`timescale 1ns / 1ps
module first_fit_unit_allocator #(
  parameter int MEM_UNITS = 1024,
  parameter int TAG_BITS  = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  ffua_req_if.sink    in_req,
  ffua_rsp_if.source  out_rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ffua_pkg::*;

  localparam int CW    = $clog2(MEM_UNITS + 1);
  localparam int MSZ_W = (CW > MEMSZ_W) ? CW : MEMSZ_W;

  logic [MSZ_W-1:0] mem_size_r;
  logic [CW-1:0]    limit;
  logic             cfg_wr;
  logic             push, pop, pop_valid;
  item_t            push_item, pop_item;
  front_ctl_t       fctl;
  logic             q_full;
  logic             clearing;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MEM_SIZE);
  assign prdata = (paddr[2] == REG_MEM_SIZE) ? 32'(mem_size_r) : '0;

  // saturate to the physical store
  assign limit = (32'(mem_size_r) > 32'(MEM_UNITS)) ? CW'(MEM_UNITS) : CW'(mem_size_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_size_r <= MSZ_W'(MEM_UNITS);
    end else if (cfg_wr) begin
      mem_size_r <= MSZ_W'(pwdata[MEMSZ_W-1:0]);
    end
  end

  assign fctl = '{full: q_full, clearing: clearing};

  ffua_front #(
    .MEM_UNITS (MEM_UNITS)
  ) u_front (
    .in_req    (in_req),
    .limit     (limit),
    .ctl       (fctl),
    .push      (push),
    .push_item (push_item)
  );

  ffua_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_item  (pop_item)
  );

  ffua_engine #(
    .MEM_UNITS (MEM_UNITS),
    .TAG_BITS  (TAG_BITS)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .limit    (limit),
    .q_valid  (pop_valid),
    .q_item   (pop_item),
    .q_pop    (pop),
    .clearing (clearing),
    .out_rsp  (out_rsp)
  );

endmodule
